### design/fte_pkg.sv
// Package for the FAT entry locator: types, widths and register indexes.
package fte_pkg;

	// Volume classes, also the code carried on the output kind field.
	typedef enum logic [1:0] {
		KIND_FAT12 = 2'd0,
		KIND_FAT16 = 2'd1,
		KIND_FAT32 = 2'd2
	} kind_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_BYTES_PER_SECTOR    = 3'd0;
	localparam logic [2:0] REG_SECTORS_PER_CLUSTER = 3'd1;
	localparam logic [2:0] REG_RESERVED_SECTORS    = 3'd2;
	localparam logic [2:0] REG_FAT_COPIES          = 3'd3;
	localparam logic [2:0] REG_ROOT_ENTRIES        = 3'd4;
	localparam logic [2:0] REG_FAT_SECTORS         = 3'd5;
	localparam logic [2:0] REG_VOLUME_SECTORS      = 3'd6;

	// Cluster count limits of the FAT12 and FAT16 classes.
	localparam logic [31:0] FAT12_LIMIT = 32'd4085;
	localparam logic [31:0] FAT16_LIMIT = 32'd65525;

	// Entry divider: table offset width, remainder width, bits per stage, stages.
	localparam int DIV_W      = 30;
	localparam int REM_W      = 13;
	localparam int DIV_STEPS  = 5;
	localparam int DIV_STAGES = DIV_W / DIV_STEPS;

	// Geometry unit state.
	typedef enum logic [2:0] {
		G_START,
		G_ROOT,
		G_SUM,
		G_LOAD,
		G_CLUS,
		G_KIND,
		G_IDLE
	} geo_state_t;

	// Derived geometry handed from the geometry unit to the pipeline.
	typedef struct packed {
		logic        busy;
		logic [12:0] bps;
		logic [15:0] reserved;
		kind_t       kind;
		logic [28:0] data_start;
		logic [31:0] clusters;
		logic        bad;
	} geo_t;

endpackage

### design/fte_geometry.sv
// Configuration registers and the serial unit that derives the volume geometry.
module fte_geometry (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_wdata,
	output fte_pkg::geo_t geo
);
	import fte_pkg::*;

	logic [12:0] bps_q;
	logic [7:0]  spc_q;
	logic [15:0] reserved_q;
	logic [7:0]  copies_q;
	logic [15:0] root_entries_q;
	logic [21:0] fat_sectors_q;
	logic [31:0] volume_q;

	geo_state_t  state_q, state_nx;
	logic [4:0]  cnt_q;
	logic [12:0] div_q;
	logic [12:0] rem_q;
	logic [31:0] quo_q;
	logic [29:0] prod_q;
	logic [31:0] first_q;
	logic [31:0] clusters_q;
	logic        bad_q;
	kind_t       kind_q;

	logic        busy;
	logic [12:0] bps_eff;
	logic [7:0]  spc_eff;
	logic [21:0] root_num;
	logic [13:0] step_t;
	logic [13:0] step_d;
	logic        step_ge;
	logic [12:0] rem_nx;
	logic        bad_nx;

	// A zero sector or cluster size is taken as one.
	assign bps_eff = (bps_q == 13'd0) ? 13'd1 : bps_q;
	assign spc_eff = (spc_q == 8'd0) ? 8'd1 : spc_q;

	// Numerator of the rounded-up root directory sector count.
	assign root_num = {1'b0, root_entries_q, 5'b0} + {9'b0, bps_eff} - 22'd1;

	// One restoring division step per cycle.
	assign step_t  = {rem_q, quo_q[31]};
	assign step_d  = step_t - {1'b0, div_q};
	assign step_ge = (step_t >= {1'b0, div_q});
	assign rem_nx  = step_ge ? step_d[12:0] : step_t[12:0];
	assign bad_nx  = (volume_q < first_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q          <= 13'd512;
			spc_q          <= 8'd1;
			reserved_q     <= 16'd1;
			copies_q       <= 8'd2;
			root_entries_q <= 16'd512;
			fat_sectors_q  <= 22'd1;
			volume_q       <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BYTES_PER_SECTOR:    bps_q          <= cfg_wdata[12:0];
				REG_SECTORS_PER_CLUSTER: spc_q          <= cfg_wdata[7:0];
				REG_RESERVED_SECTORS:    reserved_q     <= cfg_wdata[15:0];
				REG_FAT_COPIES:          copies_q       <= cfg_wdata[7:0];
				REG_ROOT_ENTRIES:        root_entries_q <= cfg_wdata[15:0];
				REG_FAT_SECTORS:         fat_sectors_q  <= cfg_wdata[21:0];
				REG_VOLUME_SECTORS:      volume_q       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// State register; every register write restarts the derivation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_START;
		end else if (cfg_we) begin
			state_q <= G_START;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and busy flag.
	always_comb begin
		state_nx = state_q;
		busy     = 1'b1;
		unique case (state_q)
			G_START: state_nx = G_ROOT;
			G_ROOT:  if (cnt_q == 5'd31) state_nx = G_SUM;
			G_SUM:   state_nx = G_LOAD;
			G_LOAD:  state_nx = G_CLUS;
			G_CLUS:  if (cnt_q == 5'd31) state_nx = G_KIND;
			G_KIND:  state_nx = G_IDLE;
			G_IDLE:  busy = 1'b0;
			default: state_nx = G_START;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else if (state_q == G_ROOT || state_q == G_CLUS) begin
			cnt_q <= cnt_q + 5'd1;
		end else begin
			cnt_q <= 5'd0;
		end
	end

	// Datapath: root sectors, first data sector, cluster count and class.
	always_ff @(posedge clk) begin
		unique case (state_q)
			G_START: begin
				prod_q <= {22'b0, copies_q} * {8'b0, fat_sectors_q};
				div_q  <= bps_eff;
				rem_q  <= 13'd0;
				quo_q  <= {10'b0, root_num};
			end
			G_ROOT, G_CLUS: begin
				rem_q <= rem_nx;
				quo_q <= {quo_q[30:0], step_ge};
			end
			G_SUM: begin
				first_q <= {16'b0, reserved_q} + {2'b0, prod_q} + {10'b0, quo_q[21:0]};
			end
			G_LOAD: begin
				bad_q <= bad_nx;
				div_q <= {5'b0, spc_eff};
				rem_q <= 13'd0;
				quo_q <= bad_nx ? 32'd0 : (volume_q - first_q);
			end
			G_KIND: begin
				clusters_q <= quo_q;
				priority if (quo_q < FAT12_LIMIT) kind_q <= KIND_FAT12;
				else if (quo_q < FAT16_LIMIT) kind_q <= KIND_FAT16;
				else kind_q <= KIND_FAT32;
			end
			default: ;
		endcase
	end

	// Derived geometry, packed in the field order of the hand-over type.
	assign geo = {busy, bps_eff, reserved_q, kind_q, first_q[28:0], clusters_q, bad_q};

endmodule

### design/fte_div_stage.sv
// One stage of the pipelined entry divider, a few restoring steps deep.
module fte_div_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      valid_in,
	input  logic [fte_pkg::REM_W-1:0] rem_in,
	input  logic [fte_pkg::DIV_W-1:0] quo_in,
	input  logic [fte_pkg::REM_W-1:0] divisor,
	output logic                      valid_sn,
	output logic [fte_pkg::REM_W-1:0] rem_sn,
	output logic [fte_pkg::DIV_W-1:0] quo_sn
);
	import fte_pkg::*;

	logic [REM_W-1:0] rem_nx;
	logic [DIV_W-1:0] quo_nx;

	// Shift one dividend bit into the remainder per step, keep the quotient bit.
	always_comb begin
		logic [REM_W:0]   t;
		logic [REM_W:0]   d;
		logic             ge;
		logic [REM_W-1:0] r;
		logic [DIV_W-1:0] q;
		r = rem_in;
		q = quo_in;
		for (int k = 0; k < DIV_STEPS; k++) begin
			t  = {r, q[DIV_W-1]};
			d  = t - {1'b0, divisor};
			ge = (t >= {1'b0, divisor});
			r  = ge ? d[REM_W-1:0] : t[REM_W-1:0];
			q  = {q[DIV_W-2:0], ge};
		end
		rem_nx = r;
		quo_nx = q;
	end

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= valid_in;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_sn <= rem_nx;
			quo_sn <= quo_nx;
		end
	end

endmodule

### design/fat_table_entry_locator.sv
// Top level of the FAT entry locator: geometry unit and entry address pipeline.
//
// Configuration: cfg_we, cfg_index and cfg_wdata write one geometry register
// per cycle. After reset and after every register write the geometry unit
// derives the root directory size, first data sector, cluster count and
// volume class; s_tready stays low during that time.
// Write the registers only while no transfer is in flight.
//
// Input channel (s_*): one cluster number per transfer.
// Output channel (m_*): one result per input, in order: the sector and byte
// offset of the cluster's FAT entry, plus the volume geometry.
//
// An input transfer reaches m_tvalid through the pipeline: one stage forms the
// table offset, six stages divide it by the sector size five bits at a time,
// and the output stage adds the reserved sectors. One transfer is taken
// every cycle while the geometry unit is idle. When m_tready is low while
// a result waits, the whole pipeline holds and s_tready drops; nothing is
// lost or repeated. Reset clears all valid bits, restores default geometry.
module fat_table_entry_locator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [27:0] cluster_number
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // [21:0] entry_sector, [33:22] entry_byte_offset,
	                                // [62:34] data_start_sector, [94:63] data_clusters
	output logic [2:0]   m_tuser    // [1:0] volume_kind, [2] geometry_error
);
	import fte_pkg::*;

	geo_t             geo;
	logic             en;
	logic             accept;
	logic [27:0]      cluster;
	logic [DIV_W-1:0] table_off;

	logic             valid_s1;
	logic [DIV_W-1:0] off_s1;

	logic [DIV_STAGES:0] stage_valid;
	logic [REM_W-1:0]    stage_rem [DIV_STAGES+1];
	logic [DIV_W-1:0]    stage_quo [DIV_STAGES+1];

	logic             valid_s8;
	logic [21:0]      sector_s8;
	logic [11:0]      offset_s8;

	fte_geometry u_geometry (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.geo       (geo)
	);

	// The pipeline moves whenever the output register is free or being taken.
	assign en       = !valid_s8 || m_tready;
	assign s_tready = en && !geo.busy;
	assign accept   = s_tvalid && s_tready;
	assign cluster  = s_tdata[27:0];

	// Table offset: 4, 2 or 1.5 bytes per entry depending on the class.
	always_comb begin
		unique case (geo.kind)
			KIND_FAT32: table_off = {cluster, 2'b00};
			KIND_FAT16: table_off = {1'b0, cluster, 1'b0};
			default:    table_off = {2'b0, cluster} + {3'b0, cluster[27:1]};
		endcase
	end

	// First stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
		end
	end

	// First stage payload.
	always_ff @(posedge clk) begin
		if (en) begin
			off_s1 <= table_off;
		end
	end

	assign stage_valid[0] = valid_s1;
	assign stage_rem[0]   = REM_W'(0);
	assign stage_quo[0]   = off_s1;

	// Divider stages: quotient and remainder of the offset by the sector size.
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		fte_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (stage_valid[g]),
			.rem_in   (stage_rem[g]),
			.quo_in   (stage_quo[g]),
			.divisor  (geo.bps),
			.valid_sn (stage_valid[g+1]),
			.rem_sn   (stage_rem[g+1]),
			.quo_sn   (stage_quo[g+1])
		);
	end

	// Output stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s8 <= stage_valid[DIV_STAGES];
		end
	end

	// Output stage: the entry sector counts from the start of the volume, past the reserved sectors.
	always_ff @(posedge clk) begin
		if (en) begin
			sector_s8 <= {6'b0, geo.reserved} + stage_quo[DIV_STAGES][21:0];
			offset_s8 <= stage_rem[DIV_STAGES][11:0];
		end
	end

	assign m_tvalid = valid_s8;
	assign m_tdata  = {1'b0, geo.clusters, geo.data_start, offset_s8, sector_s8};
	assign m_tuser  = {geo.bad, geo.kind};

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the FAT entry locator: directed table, random geometries, stalls.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fte_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 10;
	localparam int TARGET_ITEMS = 1950;
	localparam int HOLD_CYCLES  = 200;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_PRINTS   = 100;
	localparam longint unsigned DIRENT_BYTES = 32;
	localparam logic [27:0] CLUSTER_MAX = 28'hFFFFFFF;

	// One located FAT entry together with the volume geometry reported beside it.
	typedef struct packed {
		logic [21:0] sector;
		logic [11:0] byte_offset;
		kind_t       kind;
		logic [28:0] data_start;
		logic [31:0] data_clusters;
		logic        geo_error;
	} entry_loc_t;

	// A row of the directed table: either a register write or a cluster lookup.
	typedef struct {
		bit          is_cfg;
		logic [2:0]  reg_idx;
		logic [31:0] value;
		logic [27:0] cluster;
		bit          typed;
		entry_loc_t  want;
	} stim_row_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [31:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic [2:0]   m_tuser;

	// Shadow copy of the geometry registers.
	logic [12:0]  sh_bps;
	logic [7:0]   sh_spc;
	logic [15:0]  sh_reserved;
	logic [7:0]   sh_copies;
	logic [15:0]  sh_root;
	logic [21:0]  sh_fat;
	logic [31:0]  sh_volume;

	// Typed expectation that travels with the lookup currently offered.
	bit           typed_row;
	entry_loc_t   typed_want;

	entry_loc_t   pending_entries[$];
	stim_row_t    directed_rows[$];
	bit           steady;
	bit           hold_req;
	int           mismatches;
	int           lookups;
	int           settings;
	int           kinds_seen[3];
	int           bad_geometries;
	int           quiet_cycles;

	fat_table_entry_locator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// First sector of the data region at full precision.
	function automatic longint unsigned first_data_sector();
		longint unsigned bps, root, reserved, copies, fat;
		bps = (sh_bps == 0) ? 1 : sh_bps;
		root = sh_root;
		reserved = sh_reserved;
		copies = sh_copies;
		fat = sh_fat;
		return reserved + copies * fat + (root * DIRENT_BYTES + bps - 1) / bps;
	endfunction

	// Works out where the FAT entry of a cluster lies under the current geometry.
	function automatic entry_loc_t locate_entry(logic [27:0] cluster);
		longint unsigned bps, spc, n, volume, first_data, clusters, table_off, sector;
		longint unsigned rem;
		entry_loc_t r;
		bps = (sh_bps == 0) ? 1 : sh_bps;
		spc = (sh_spc == 0) ? 1 : sh_spc;
		n = cluster;
		volume = sh_volume;
		first_data = first_data_sector();
		r.geo_error = volume < first_data;
		clusters = r.geo_error ? 0 : (volume - first_data) / spc;
		if (clusters < FAT12_LIMIT) begin
			r.kind = KIND_FAT12;
			table_off = n + (n >> 1);
		end else if (clusters < FAT16_LIMIT) begin
			r.kind = KIND_FAT16;
			table_off = n * 2;
		end else begin
			r.kind = KIND_FAT32;
			table_off = n * 4;
		end
		sector = sh_reserved + table_off / bps;
		rem = table_off % bps;
		r.sector = sector[21:0];
		r.byte_offset = rem[11:0];
		r.data_start = first_data[28:0];
		r.data_clusters = clusters[31:0];
		return r;
	endfunction

	function automatic void add_cfg(logic [2:0] idx, logic [31:0] value);
		stim_row_t row;
		row = '{is_cfg: 1'b1, reg_idx: idx, value: value, cluster: '0, typed: 1'b0, want: '0};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_item(logic [27:0] cluster);
		stim_row_t row;
		row = '{is_cfg: 1'b0, reg_idx: '0, value: '0, cluster: cluster, typed: 1'b0, want: '0};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_checked(logic [27:0] cluster, logic [21:0] sector,
			logic [11:0] byte_offset, kind_t kind, logic [28:0] data_start,
			logic [31:0] data_clusters, logic geo_error);
		stim_row_t row;
		row = '{is_cfg: 1'b0, reg_idx: '0, value: '0, cluster: cluster, typed: 1'b1,
			want: '{sector, byte_offset, kind, data_start, data_clusters, geo_error}};
		directed_rows.push_back(row);
	endfunction

	task automatic flag_mismatch(input string msg);
		if (mismatches < MAX_PRINTS)
			$display("ERROR at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input longint unsigned got,
			input longint unsigned want);
		if (got != want)
			flag_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// Drives one register write; the caller lowers the write enable after the last one.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_BYTES_PER_SECTOR: begin
				sh_bps = value[12:0];
			end
			REG_SECTORS_PER_CLUSTER: begin
				sh_spc = value[7:0];
			end
			REG_RESERVED_SECTORS: begin
				sh_reserved = value[15:0];
			end
			REG_FAT_COPIES: begin
				sh_copies = value[7:0];
			end
			REG_ROOT_ENTRIES: begin
				sh_root = value[15:0];
			end
			REG_FAT_SECTORS: begin
				sh_fat = value[21:0];
			end
			REG_VOLUME_SECTORS: begin
				sh_volume = value;
			end
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	// Stops offering lookups and waits for every outstanding result; the first edge
	// lets the scoreboard log a lookup taken at the edge the caller returned on.
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_entries.size() != 0)
			@(posedge clk);
	endtask

	// Offers one cluster number after a random gap and waits for its transfer.
	task automatic send_cluster(input logic [27:0] cluster, input bit typed,
			input entry_loc_t want);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, cluster};
		typed_row <= typed;
		typed_want <= want;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Scoreboard: check each result against the oldest expectation, then log new lookups.
	always @(posedge clk) begin
		entry_loc_t got;
		entry_loc_t want;
		if (m_tvalid && m_tready) begin
			got.sector = m_tdata[21:0];
			got.byte_offset = m_tdata[33:22];
			got.data_start = m_tdata[62:34];
			got.data_clusters = m_tdata[94:63];
			got.kind = kind_t'(m_tuser[1:0]);
			got.geo_error = m_tuser[2];
			if (pending_entries.size() == 0) begin
				flag_mismatch("result transfer with no lookup outstanding");
			end else begin
				want = pending_entries.pop_front();
				compare_field("entry_sector", got.sector, want.sector);
				compare_field("entry_byte_offset", got.byte_offset, want.byte_offset);
				compare_field("volume_kind", got.kind, want.kind);
				compare_field("data_start_sector", got.data_start, want.data_start);
				compare_field("data_clusters", got.data_clusters, want.data_clusters);
				compare_field("geometry_error", got.geo_error, want.geo_error);
				if (want.kind <= KIND_FAT32)
					kinds_seen[want.kind]++;
				if (want.geo_error)
					bad_geometries++;
			end
		end
		if (s_tvalid && s_tready) begin
			pending_entries.push_back(typed_row ? typed_want : locate_entry(s_tdata[27:0]));
			lookups++;
		end
	end

	// Count cycles in which nothing moves on any port.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("fat_table_entry_locator regression: fail");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = steady ? 0 : $urandom_range(0, 3);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
		end
	end

	// Main sequence: reset, directed table, then random geometries.
	initial begin
		logic [12:0] bps;
		logic [7:0]  spc;
		logic [15:0] reserved;
		logic [7:0]  copies;
		logic [15:0] root;
		logic [21:0] fat;
		longint unsigned fd, spc_eff, target, vol, clusters;
		int unsigned cmax;
		int pick;
		int count;
		int phase;
		logic [27:0] cluster;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		typed_row = 1'b0;
		typed_want = '0;
		steady = 1'b0;
		hold_req = 1'b0;
		mismatches = 0;
		lookups = 0;
		settings = 1;
		kinds_seen = '{0, 0, 0};
		bad_geometries = 0;
		quiet_cycles = 0;
		// Geometry after reset
		sh_bps = 13'd512;
		sh_spc = 8'd1;
		sh_reserved = 16'd1;
		sh_copies = 8'd2;
		sh_root = 16'd512;
		sh_fat = 22'd1;
		sh_volume = 32'd0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset geometry: 35 sectors before data, empty volume, so a geometry error.
		add_checked(28'd0, 22'd1, 12'd0, KIND_FAT12, 29'd35, 32'd0, 1'b1);
		add_checked(CLUSTER_MAX, 22'd786432, 12'd510, KIND_FAT12, 29'd35, 32'd0, 1'b1);
		add_item(28'd1);
		add_item(28'h5555555);
		add_item(28'hAAAAAAA);
		// One sector short of the data region, then exactly at it.
		add_cfg(REG_VOLUME_SECTORS, 32'd34);
		add_checked(28'd3, 22'd1, 12'd4, KIND_FAT12, 29'd35, 32'd0, 1'b1);
		add_cfg(REG_VOLUME_SECTORS, 32'd35);
		add_item(28'd3);
		// Both sides of the FAT12 and FAT16 class limits.
		add_cfg(REG_VOLUME_SECTORS, 32'd4119);
		add_item(28'd4084);
		add_cfg(REG_VOLUME_SECTORS, 32'd4120);
		add_checked(CLUSTER_MAX, 22'd1048576, 12'd510, KIND_FAT16, 29'd35, 32'd4085, 1'b0);
		add_item(28'd7);
		add_cfg(REG_VOLUME_SECTORS, 32'd65559);
		add_item(28'd9);
		add_cfg(REG_VOLUME_SECTORS, 32'd65560);
		add_checked(28'd9, 22'd1, 12'd36, KIND_FAT32, 29'd35, 32'd65525, 1'b0);
		add_item(CLUSTER_MAX);
		add_cfg(REG_VOLUME_SECTORS, 32'hFFFFFFFF);
		add_item(28'h5555555);
		// Zero sector and cluster sizes count as one.
		add_cfg(REG_BYTES_PER_SECTOR, 32'd0);
		add_item(28'd1000);
		add_item(CLUSTER_MAX);
		add_cfg(REG_SECTORS_PER_CLUSTER, 32'd0);
		add_item(28'd123);
		// Every register at its widest, so the reported sums wrap.
		add_cfg(REG_BYTES_PER_SECTOR, 32'h1FFF);
		add_cfg(REG_SECTORS_PER_CLUSTER, 32'hFF);
		add_cfg(REG_RESERVED_SECTORS, 32'hFFFF);
		add_cfg(REG_FAT_COPIES, 32'hFF);
		add_cfg(REG_ROOT_ENTRIES, 32'hFFFF);
		add_cfg(REG_FAT_SECTORS, 32'h3FFFFF);
		add_item(CLUSTER_MAX);
		add_item(28'd0);
		// Sector size 4096 and 128 sectors per cluster with every count at zero.
		add_cfg(REG_BYTES_PER_SECTOR, 32'd4096);
		add_cfg(REG_SECTORS_PER_CLUSTER, 32'd128);
		add_cfg(REG_RESERVED_SECTORS, 32'd0);
		add_cfg(REG_FAT_COPIES, 32'd0);
		add_cfg(REG_ROOT_ENTRIES, 32'd0);
		add_cfg(REG_FAT_SECTORS, 32'd0);
		add_cfg(REG_VOLUME_SECTORS, 32'd0);
		add_item(28'd77);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				if (i == 0 || !directed_rows[i - 1].is_cfg)
					settle_idle();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
				if (i + 1 == directed_rows.size() || !directed_rows[i + 1].is_cfg) begin
					cfg_we <= 1'b0;
					settings++;
				end
			end else begin
				send_cluster(directed_rows[i].cluster, directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		// Random geometries, each followed by a run of lookups.
		phase = 0;
		while (lookups < TARGET_ITEMS) begin
			settle_idle();
			bps = ($urandom_range(0, 9) < 8) ? (13'd512 << $urandom_range(0, 3))
				: 13'($urandom_range(0, 8191));
			spc = ($urandom_range(0, 9) < 8) ? (8'd1 << $urandom_range(0, 7))
				: 8'($urandom_range(0, 255));
			reserved = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(1, 64))
				: 16'($urandom_range(0, 65535));
			copies = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 2))
				: 8'($urandom_range(0, 255));
			case ($urandom_range(0, 2))
				0: root = 16'd0;
				1: root = 16'd512;
				default: root = 16'($urandom_range(0, 65535));
			endcase
			fat = ($urandom_range(0, 3) != 0) ? 22'($urandom_range(1, 4096))
				: 22'($urandom_range(0, 22'h3FFFFF));
			write_reg(REG_BYTES_PER_SECTOR, 32'(bps));
			write_reg(REG_SECTORS_PER_CLUSTER, 32'(spc));
			write_reg(REG_RESERVED_SECTORS, 32'(reserved));
			write_reg(REG_FAT_COPIES, 32'(copies));
			write_reg(REG_ROOT_ENTRIES, 32'(root));
			write_reg(REG_FAT_SECTORS, 32'(fat));

			// Aim the volume size at a class limit, a class interior, below the data region or at random.
			fd = first_data_sector();
			spc_eff = (sh_spc == 0) ? 1 : sh_spc;
			pick = $urandom_range(0, 7);
			case (pick)
				0: target = 4083 + $urandom_range(0, 4);
				1: target = 65523 + $urandom_range(0, 4);
				2: target = $urandom_range(0, 4084);
				3: target = $urandom_range(4085, 65524);
				4: target = $urandom_range(65525, 4000000);
				default: target = $urandom_range(0, 200000);
			endcase
			if (pick == 5)
				vol = (fd == 0) ? 0 : fd - 1 - ($urandom_range(0, 1000) % fd);
			else if (pick == 6)
				vol = $urandom;
			else
				vol = fd + target * spc_eff + $urandom_range(0, 32'(spc_eff - 1));
			if (vol > 64'hFFFFFFFF)
				vol = $urandom;
			write_reg(REG_VOLUME_SECTORS, vol[31:0]);
			cfg_we <= 1'b0;
			settings++;

			steady = ($urandom_range(0, 3) == 0);
			count = $urandom_range(10, 60);
			// One run holds the result side off long enough to back up the pipeline.
			if (phase == 2) begin
				hold_req = 1'b1;
				count = 80;
			end
			clusters = locate_entry(28'd0).data_clusters;
			cmax = (clusters + 1 > CLUSTER_MAX) ? CLUSTER_MAX : 32'(clusters + 1);
			repeat (count) begin
				cluster = $urandom_range(0, 1) ? 28'($urandom) : 28'($urandom_range(0, cmax));
				send_cluster(cluster, 1'b0, '0);
			end
			phase++;
		end

		settle_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Located %0d FAT entries over %0d geometry settings.", lookups, settings);
		$display("Classes seen: FAT12 %0d, FAT16 %0d, FAT32 %0d; bad geometry %0d.",
			kinds_seen[0], kinds_seen[1], kinds_seen[2], bad_geometries);
		if (mismatches == 0)
			$display("fat_table_entry_locator regression: pass");
		else
			$display("fat_table_entry_locator regression: fail");
		$finish;
	end

endmodule
